/* rtl/core/rclr_pkg.sv */
// ----------------------------------------------------------------------------
// rclr_pkg
// shared types, constants and the crc-8 byte step for the rc link receiver
// ----------------------------------------------------------------------------
package rclr_pkg;

	localparam int FRAME_BYTES_MAX = 64;
	localparam int CHANNEL_COUNT   = 16;
	localparam int ADDR_W          = $clog2(FRAME_BYTES_MAX);
	localparam int LEN_W           = ADDR_W + 1;

	localparam logic [7:0] SYNC_BYTE = 8'hC8;
	localparam logic [7:0] CRC_POLY  = 8'hD5;
	localparam logic [7:0] LEN_MIN   = 8'd3;
	localparam logic [7:0] LEN_MAX   = 8'(FRAME_BYTES_MAX - 2);

	// first byte that holds channel bits
	localparam logic [ADDR_W-1:0] CH_BASE = ADDR_W'(3);

	localparam logic [10:0] RAW_MIN   = 11'd162;
	localparam logic [10:0] RAW_LOW   = 11'd191;
	localparam logic [10:0] RAW_HIGH  = 11'd1792;
	localparam logic [10:0] RAW_MAX   = 11'd1821;
	localparam logic [10:0] VAL_BASE  = 11'd1000;
	localparam int          SPAN      = 1601;
	localparam int          QUOT_BITS = 10;

	// register indexes
	localparam logic [1:0] REG_FRAME_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_LINK_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_CHANNEL_TYPE  = 2'd2;

	// input operations
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_CHANNEL  = 2'd0;
	localparam logic [1:0] KIND_CRC_BAD  = 2'd1;
	localparam logic [1:0] KIND_OTHER    = 2'd2;
	localparam logic [1:0] KIND_LINKLOST = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_STATUS
	} top_state_t;

	typedef enum logic [2:0] {
		UP_IDLE,
		UP_FETCH,
		UP_LOAD,
		UP_SHIFT,
		UP_SCALE,
		UP_WAIT,
		UP_OUT
	} unpack_state_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_DIV,
		SC_DONE
	} scale_state_t;

	// frame store write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} store_wr_t;

	// channel result from the unpacker
	typedef struct packed {
		logic        emit;
		logic [3:0]  index;
		logic [10:0] value;
		logic        last;
	} chan_res_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/core/rclr_scale.sv */
// ----------------------------------------------------------------------------
// rclr_scale
// bounds and scales a raw channel to 1000..2000 (zero out of range) with a shift-subtract divider
// ----------------------------------------------------------------------------
module rclr_scale (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [10:0] raw,
	output logic        done,
	output logic [10:0] value
);

	localparam logic [20:0] DIV_TOP = 21'(rclr_pkg::SPAN * (2 ** (rclr_pkg::QUOT_BITS - 1)));

	rclr_pkg::scale_state_t state_q, state_d;
	logic [20:0] rem_q;
	logic [20:0] div_q;
	logic [9:0]  quot_q;
	logic [3:0]  step_q;
	logic        zero_q;
	logic [10:0] x;
	logic [20:0] prod;

	// clamp into the live band and form x * 1000
	always_comb begin
		if (raw < rclr_pkg::RAW_LOW) begin
			x = 11'd0;
		end else if (raw > rclr_pkg::RAW_HIGH) begin
			x = rclr_pkg::RAW_HIGH - rclr_pkg::RAW_LOW;
		end else begin
			x = raw - rclr_pkg::RAW_LOW;
		end
		prod = {x, 10'b0} - {6'b0, x, 4'b0} - {7'b0, x, 3'b0};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rclr_pkg::SC_IDLE: begin
				if (start) begin
					state_d = rclr_pkg::SC_DIV;
				end
			end
			rclr_pkg::SC_DIV: begin
				if (zero_q || step_q == 4'(rclr_pkg::QUOT_BITS - 1)) begin
					state_d = rclr_pkg::SC_DONE;
				end
			end
			rclr_pkg::SC_DONE: state_d = rclr_pkg::SC_IDLE;
			default: state_d = rclr_pkg::SC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rclr_pkg::SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == rclr_pkg::SC_IDLE && start) begin
			rem_q  <= prod;
			div_q  <= DIV_TOP;
			quot_q <= '0;
			step_q <= '0;
			zero_q <= (raw < rclr_pkg::RAW_MIN) || (raw > rclr_pkg::RAW_MAX);
		end else if (state_q == rclr_pkg::SC_DIV) begin
			if (rem_q >= div_q) begin
				rem_q  <= rem_q - div_q;
				quot_q <= {quot_q[8:0], 1'b1};
			end else begin
				quot_q <= {quot_q[8:0], 1'b0};
			end
			div_q  <= {1'b0, div_q[20:1]};
			step_q <= step_q + 4'd1;
		end
	end

	assign done  = (state_q == rclr_pkg::SC_DONE);
	assign value = zero_q ? 11'd0 : ({1'b0, quot_q} + rclr_pkg::VAL_BASE);

endmodule

/* rtl/core/rclr_unpack.sv */
// ----------------------------------------------------------------------------
// rclr_unpack
// frame store and bit-serial channel unpacker, one channel bit per cycle while in the shift state
// ----------------------------------------------------------------------------
module rclr_unpack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rclr_pkg::store_wr_t            wr,
	input  logic [rclr_pkg::LEN_W-1:0]     total_len,
	input  logic                           start,
	input  logic                           out_free,
	output logic                           busy,
	output rclr_pkg::chan_res_t            res
);

	logic [7:0] mem [rclr_pkg::FRAME_BYTES_MAX];

	rclr_pkg::unpack_state_t state_q, state_d;
	logic [rclr_pkg::ADDR_W-1:0] rd_addr_q;
	logic [7:0]  rdata_q;
	logic        rd_valid_q;
	logic [7:0]  byte_q;
	logic [3:0]  bits_left_q;
	logic [10:0] raw_q;
	logic [3:0]  raw_cnt_q;
	logic [3:0]  ch_q;
	logic [10:0] value_q;
	logic        sc_start;
	logic        sc_done;
	logic [10:0] sc_value;
	logic        ch_last;

	// frame store, entries past the frame length read as zero
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (state_q == rclr_pkg::UP_FETCH) begin
			rdata_q    <= mem[rd_addr_q];
			rd_valid_q <= ({1'b0, rd_addr_q} < total_len);
		end
	end

	assign ch_last = (ch_q == 4'(rclr_pkg::CHANNEL_COUNT - 1));

	// sequencer
	always_comb begin
		state_d  = state_q;
		sc_start = 1'b0;
		case (state_q)
			rclr_pkg::UP_IDLE: begin
				if (start) begin
					state_d = rclr_pkg::UP_FETCH;
				end
			end
			rclr_pkg::UP_FETCH: state_d = rclr_pkg::UP_LOAD;
			rclr_pkg::UP_LOAD:  state_d = rclr_pkg::UP_SHIFT;
			rclr_pkg::UP_SHIFT: begin
				if (raw_cnt_q == 4'd10) begin
					state_d = rclr_pkg::UP_SCALE;
				end else if (bits_left_q == 4'd1) begin
					state_d = rclr_pkg::UP_FETCH;
				end
			end
			rclr_pkg::UP_SCALE: begin
				sc_start = 1'b1;
				state_d  = rclr_pkg::UP_WAIT;
			end
			rclr_pkg::UP_WAIT: begin
				if (sc_done) begin
					state_d = rclr_pkg::UP_OUT;
				end
			end
			rclr_pkg::UP_OUT: begin
				if (out_free) begin
					if (ch_last) begin
						state_d = rclr_pkg::UP_IDLE;
					end else if (bits_left_q == 4'd0) begin
						state_d = rclr_pkg::UP_FETCH;
					end else begin
						state_d = rclr_pkg::UP_SHIFT;
					end
				end
			end
			default: state_d = rclr_pkg::UP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rclr_pkg::UP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// byte buffer, channel shift register and counters
	always_ff @(posedge clk) begin
		case (state_q)
			rclr_pkg::UP_IDLE: begin
				rd_addr_q <= rclr_pkg::CH_BASE;
				raw_cnt_q <= '0;
				ch_q      <= '0;
			end
			rclr_pkg::UP_LOAD: begin
				byte_q      <= rd_valid_q ? rdata_q : 8'd0;
				bits_left_q <= 4'd8;
				rd_addr_q   <= rd_addr_q + rclr_pkg::ADDR_W'(1);
			end
			rclr_pkg::UP_SHIFT: begin
				raw_q       <= {byte_q[0], raw_q[10:1]};
				byte_q      <= {1'b0, byte_q[7:1]};
				bits_left_q <= bits_left_q - 4'd1;
				raw_cnt_q   <= (raw_cnt_q == 4'd10) ? 4'd0 : raw_cnt_q + 4'd1;
			end
			rclr_pkg::UP_WAIT: begin
				if (sc_done) begin
					value_q <= sc_value;
				end
			end
			rclr_pkg::UP_OUT: begin
				if (out_free) begin
					ch_q <= ch_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	rclr_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.raw    (raw_q),
		.done   (sc_done),
		.value  (sc_value)
	);

	assign busy      = (state_q != rclr_pkg::UP_IDLE);
	assign res.emit  = (state_q == rclr_pkg::UP_OUT) && out_free;
	assign res.index = ch_q;
	assign res.value = value_q;
	assign res.last  = ch_last;

endmodule

/* rtl/core/rc_link_frame_receiver.sv */
// ----------------------------------------------------------------------------
// rc_link_frame_receiver
// rc link frame receiver: sync hunt, crc-8 check and sixteen-channel decode
// ----------------------------------------------------------------------------
// A byte or tick is taken whenever s_tready is high; the crc is updated as
// each byte arrives. A good channel frame then unpacks its channels
// bit-serially from the frame store: per channel the eleven raw bits are
// shifted in one by one, with one or two byte fetches through the fetch and
// load states, then a scale and divide pass (cut short when the raw value is
// out of range) and an output state that waits for the output to be free; no
// input is taken while the channels unpack. Status results (crc mismatch,
// other frame type, link lost) wait in the status state for a free output.
// The frame store needs no clearing pass: bytes past the current frame
// length read as zero.
module rc_link_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_tuser,   // [0] operation
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [3:0] channel_index, [14:4] channel_value, [15] link_lost
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = rclr_pkg::ADDR_W;
	localparam int LW = rclr_pkg::LEN_W;

	rclr_pkg::top_state_t state_q, state_d;

	logic [7:0]    frame_to_q;
	logic [15:0]   link_to_q;
	logic [7:0]    ch_type_q;
	logic [AW-1:0] pos_q;
	logic [LW-1:0] total_q;
	logic [7:0]    frame_age_q;
	logic [15:0]   link_age_q;
	logic          lost_q;
	logic [7:0]    crc_q;
	logic [7:0]    type_q;
	logic [1:0]    status_kind_q;

	logic          accept;
	logic          is_tick;
	logic          out_free;
	logic          unpack_busy;
	logic [7:0]    frame_age_inc;
	logic [15:0]   link_age_inc;
	logic          frame_end;
	logic          crc_ok;
	logic          type_ok;
	logic          link_trip;
	logic          status_go;
	logic          unpack_go;
	rclr_pkg::store_wr_t wr;
	rclr_pkg::chan_res_t ch_res;

	assign accept    = s_tvalid && s_tready;
	assign is_tick   = (s_tuser[0] == rclr_pkg::OP_TICK);
	assign out_free  = !m_tvalid || m_tready;
	assign s_tready  = (state_q == rclr_pkg::ST_IDLE) && !unpack_busy;
	assign cfg_ready = 1'b1;

	// saturating ages and decisions for the current input
	always_comb begin
		frame_age_inc = (frame_age_q == 8'hFF) ? frame_age_q : frame_age_q + 8'd1;
		link_age_inc  = (link_age_q == 16'hFFFF) ? link_age_q : link_age_q + 16'd1;
		link_trip     = !lost_q && (link_age_inc >= link_to_q);
		frame_end     = (pos_q >= AW'(2)) && !(({1'b0, pos_q} + LW'(1)) < total_q);
		crc_ok        = (crc_q == s_tdata);
		type_ok       = (type_q == ch_type_q);
		status_go     = accept && (is_tick ? link_trip : (frame_end && !(crc_ok && type_ok)));
		unpack_go     = accept && !is_tick && frame_end && crc_ok && type_ok;
		wr.en         = accept && !is_tick && (pos_q >= AW'(2));
		wr.addr       = pos_q;
		wr.data       = s_tdata;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_to_q <= 8'd2;
			link_to_q  <= 16'd100;
			ch_type_q  <= 8'd22;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rclr_pkg::REG_FRAME_TIMEOUT: frame_to_q <= cfg_data[7:0];
				rclr_pkg::REG_LINK_TIMEOUT:  link_to_q  <= cfg_data;
				rclr_pkg::REG_CHANNEL_TYPE:  ch_type_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// frame tracking, ages and link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			total_q     <= '0;
			frame_age_q <= '0;
			link_age_q  <= '0;
			lost_q      <= 1'b1;
			crc_q       <= '0;
		end else if (accept) begin
			if (is_tick) begin
				frame_age_q <= frame_age_inc;
				link_age_q  <= link_age_inc;
				if ((pos_q != '0 && frame_age_inc >= frame_to_q) || link_trip) begin
					pos_q <= '0;
				end
				if (link_trip) begin
					lost_q <= 1'b1;
				end
			end else if (pos_q == '0) begin
				if (s_tdata == rclr_pkg::SYNC_BYTE) begin
					pos_q       <= AW'(1);
					frame_age_q <= '0;
					crc_q       <= '0;
				end
			end else if (pos_q == AW'(1)) begin
				if (s_tdata >= rclr_pkg::LEN_MIN && s_tdata <= rclr_pkg::LEN_MAX) begin
					total_q <= LW'(2) + LW'(s_tdata[AW-1:0]);
					pos_q   <= AW'(2);
				end else begin
					pos_q <= '0;
				end
			end else if (!frame_end) begin
				pos_q <= pos_q + AW'(1);
				crc_q <= rclr_pkg::crc8_step(crc_q, s_tdata);
			end else begin
				pos_q <= '0;
				if (crc_ok && type_ok) begin
					lost_q     <= 1'b0;
					link_age_q <= '0;
				end
			end
		end
	end

	// frame type byte capture and status result kind
	always_ff @(posedge clk) begin
		if (accept && !is_tick && pos_q == AW'(2)) begin
			type_q <= s_tdata;
		end
		if (status_go) begin
			if (is_tick) begin
				status_kind_q <= rclr_pkg::KIND_LINKLOST;
			end else if (!crc_ok) begin
				status_kind_q <= rclr_pkg::KIND_CRC_BAD;
			end else begin
				status_kind_q <= rclr_pkg::KIND_OTHER;
			end
		end
	end

	// status result sequencing
	always_comb begin
		state_d = state_q;
		case (state_q)
			rclr_pkg::ST_IDLE: begin
				if (status_go) begin
					state_d = rclr_pkg::ST_STATUS;
				end
			end
			rclr_pkg::ST_STATUS: begin
				if (out_free) begin
					state_d = rclr_pkg::ST_IDLE;
				end
			end
			default: state_d = rclr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rclr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	rclr_unpack u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.total_len (total_q),
		.start     (unpack_go),
		.out_free  (out_free),
		.busy      (unpack_busy),
		.res       (ch_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if ((state_q == rclr_pkg::ST_STATUS && out_free) || ch_res.emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rclr_pkg::ST_STATUS && out_free) begin
			m_tuser <= status_kind_q;
			m_tdata <= {lost_q, 11'd0, 4'd0};
			m_tlast <= 1'b1;
		end else if (ch_res.emit) begin
			m_tuser <= rclr_pkg::KIND_CHANNEL;
			m_tdata <= {lost_q, ch_res.value, ch_res.index};
			m_tlast <= ch_res.last;
		end
	end

endmodule

/* rtl/core/rclr_checker.sv */
// ----------------------------------------------------------------------------
// rclr_checker
// port-level checks on the result stream of the rc link frame receiver
// ----------------------------------------------------------------------------
module rclr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// channel values are zero or within 1000..2000
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == rclr_pkg::KIND_CHANNEL |->
		(m_tdata[14:4] == 11'd0 || (m_tdata[14:4] >= 11'd1000 && m_tdata[14:4] <= 11'd2000)))
		else $error("channel value out of range");

	// status results are single, empty results
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != rclr_pkg::KIND_CHANNEL |->
		m_tlast && m_tdata[14:0] == 15'd0)
		else $error("malformed status result");

	// link lost result shows the link lost flag
	a_lost: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == rclr_pkg::KIND_LINKLOST |-> m_tdata[15])
		else $error("link lost result without flag");

	// channel results follow a good frame, so the link is up
	a_up: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == rclr_pkg::KIND_CHANNEL |-> !m_tdata[15])
		else $error("channel result with link lost");

endmodule

bind rc_link_frame_receiver rclr_checker u_rclr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
